// File: rtl/core/sorted_record_table_search_defines.svh
// Assertion macros used by the record table search top level.
`ifndef SORTED_RECORD_TABLE_SEARCH_DEFINES_SVH
`define SORTED_RECORD_TABLE_SEARCH_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define SRTS_ASSERT_NOW(label, trig, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error("srts check failed");

// Property that must hold in the cycle after its trigger.
`define SRTS_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("srts check failed");

`endif

// File: rtl/core/srts_pkg.sv
// Types and constants of the sorted record table search block.
package srts_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned POS_W = 6;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic MODE_BINARY = 1'b0;
  localparam logic MODE_SEQ    = 1'b1;

  localparam logic [1:0] STAT_LOADED   = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd1;
  localparam logic [1:0] STAT_FOUND    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic                    operation;
    logic                    first_record;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] found_key;
    logic [PAY_W-1:0]        found_payload;
    logic [POS_W-1:0]        position;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } rec_t;

endpackage

// File: rtl/core/srts_ram.sv
// Record table storage: one write port and one registered read port.
module srts_ram #(
  parameter int unsigned DEPTH = srts_pkg::DEFAULT_DEPTH,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IW-1:0]       waddr_i,
  input  srts_pkg::rec_t      wdata_i,
  input  logic [IW-1:0]       raddr_i,
  output srts_pkg::rec_t      rdata_o
);
  import srts_pkg::*;

  rec_t mem [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/srts_cmp.sv
// Shared signed key comparator used by both the sort and the searches.
module srts_cmp (
  input  logic signed [srts_pkg::KEY_W-1:0] a_i,
  input  logic signed [srts_pkg::KEY_W-1:0] b_i,
  output logic                              eq_o,
  output logic                              lt_o
);
  import srts_pkg::*;

  assign eq_o = (a_i == b_i);
  assign lt_o = (a_i < b_i);

endmodule

// File: rtl/core/sorted_record_table_search.sv
// Top level: record table with bubble sort and binary or sequential search.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o  in_data_i (in_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_t)
//   cfg       input      cfg_we_i                cfg_wdata_i (search mode)
//
// A search first sorts the table if loads came in since the last sort; each sort
// compare step and each search probe first reads a record and then compares it,
// since the table memory has a single registered read port.
// Reset empties the table; its contents are undefined until loaded.
// A stalled output holds its result; the block stalls its input meanwhile.
`include "sorted_record_table_search_defines.svh"

module sorted_record_table_search #(
  parameter int unsigned TABLE_DEPTH = srts_pkg::DEFAULT_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  srts_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output srts_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);
  import srts_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDH, S_HOLD, S_RDN, S_CMP, S_WEND, S_START,
    S_BCHK, S_BCMP, S_QRD, S_QCMP, S_QFIN
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  top_q, top_d;
  logic [CW-1:0]  count_q, count_d;
  logic [IW-1:0]  mid_q, mid_d;
  logic [IW-1:0]  pend_pos_q, pend_pos_d;
  logic           pend_v_q, pend_v_d;
  logic           needs_sort_q, needs_sort_d;
  logic           mode_q;
  rec_t           hold_q, hold_d;
  rec_t           pend_q, pend_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  out_t           out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic           can_emit, in_fire;
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  rec_t           wdata, rdata;
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic           cmp_eq, cmp_lt;
  logic [CW:0]    mid_sum;
  logic [CW-1:0]  widx;

  function automatic out_t mk_out(logic [1:0] st, rec_t r, logic [POS_W-1:0] pos,
                                  logic lst);
    out_t o;
    o.status        = st;
    o.found_key     = r.key;
    o.found_payload = r.payload;
    o.position      = pos;
    o.last          = lst;
    return o;
  endfunction

  srts_ram #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  srts_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .eq_o (cmp_eq),
    .lt_o (cmp_lt)
  );

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !can_emit;
  assign in_fire    = in_valid_i && !in_stall_o;
  // Sum of lo and hi, halved for the midpoint, where top_q holds hi + 1.
  assign mid_sum    = {1'b0, idx_q} + {1'b0, top_q} - (CW+1)'(1);
  assign widx       = in_data_i.first_record ? '0 : count_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    top_d        = top_q;
    count_d      = count_q;
    mid_d        = mid_q;
    pend_pos_d   = pend_pos_q;
    pend_v_d     = pend_v_q;
    needs_sort_d = needs_sort_q;
    hold_d       = hold_q;
    pend_d       = pend_q;
    key_d        = key_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    we           = 1'b0;
    waddr        = idx_q[IW-1:0];
    wdata        = hold_q;
    raddr        = '0;
    cmp_a        = key_q;
    cmp_b        = rdata.key;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == OP_LOAD) begin
            out_valid_d = 1'b1;
            if (widx == CW'(TABLE_DEPTH)) begin
              out_d = mk_out(STAT_DROPPED, '0, '0, 1'b1);
            end else begin
              we           = 1'b1;
              waddr        = widx[IW-1:0];
              wdata        = '{key: in_data_i.key, payload: in_data_i.payload};
              out_d        = mk_out(STAT_LOADED, '0, POS_W'(widx), 1'b1);
              count_d      = widx + CW'(1);
              needs_sort_d = 1'b1;
            end
          end else begin
            key_d        = in_data_i.key;
            needs_sort_d = 1'b0;
            if (needs_sort_q && (count_q >= CW'(2))) begin
              top_d   = count_q - CW'(1);
              state_d = S_RDH;
            end else begin
              state_d = S_START;
            end
          end
        end
      end
      S_RDH: begin
        raddr   = '0;
        state_d = S_HOLD;
      end
      S_HOLD: begin
        hold_d  = rdata;
        idx_d   = '0;
        state_d = S_RDN;
      end
      S_RDN: begin
        raddr   = IW'(idx_q + CW'(1));
        state_d = S_CMP;
      end
      S_CMP: begin
        // The larger record bubbles on in hold_q; ties keep their order.
        cmp_a = rdata.key;
        cmp_b = hold_q.key;
        we    = 1'b1;
        waddr = idx_q[IW-1:0];
        if (cmp_lt) begin
          wdata = rdata;
        end else begin
          wdata  = hold_q;
          hold_d = rdata;
        end
        idx_d   = idx_q + CW'(1);
        state_d = (idx_q + CW'(1) == top_q) ? S_WEND : S_RDN;
      end
      S_WEND: begin
        we      = 1'b1;
        waddr   = top_q[IW-1:0];
        wdata   = hold_q;
        top_d   = top_q - CW'(1);
        state_d = (top_q == CW'(1)) ? S_START : S_RDH;
      end
      S_START: begin
        idx_d    = '0;
        pend_v_d = 1'b0;
        if (mode_q == MODE_BINARY) begin
          top_d   = count_q;
          state_d = S_BCHK;
        end else begin
          state_d = S_QRD;
        end
      end
      S_BCHK: begin
        if (idx_q >= top_q) begin
          if (can_emit) begin
            out_d       = mk_out(STAT_NOTFOUND, '0, '0, 1'b1);
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          mid_d   = IW'(mid_sum >> 1);
          raddr   = IW'(mid_sum >> 1);
          state_d = S_BCMP;
        end
      end
      S_BCMP: begin
        raddr = mid_q;
        if (cmp_eq) begin
          if (can_emit) begin
            out_d       = mk_out(STAT_FOUND, rdata, POS_W'(mid_q), 1'b1);
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          if (cmp_lt) begin
            top_d = CW'(mid_q);
          end else begin
            idx_d = CW'(mid_q) + CW'(1);
          end
          state_d = S_BCHK;
        end
      end
      S_QRD: begin
        raddr = idx_q[IW-1:0];
        if (idx_q == count_q) begin
          state_d = S_QFIN;
        end else begin
          state_d = S_QCMP;
        end
      end
      S_QCMP: begin
        // A match is held back until the next one shows it was not the last.
        raddr = idx_q[IW-1:0];
        if (!cmp_eq) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_QRD;
        end else if (!pend_v_q || can_emit) begin
          if (pend_v_q) begin
            out_d       = mk_out(STAT_FOUND, pend_q, POS_W'(pend_pos_q), 1'b0);
            out_valid_d = 1'b1;
          end
          pend_d     = rdata;
          pend_pos_d = idx_q[IW-1:0];
          pend_v_d   = 1'b1;
          idx_d      = idx_q + CW'(1);
          state_d    = S_QRD;
        end
      end
      S_QFIN: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          if (pend_v_q) begin
            out_d = mk_out(STAT_FOUND, pend_q, POS_W'(pend_pos_q), 1'b1);
          end else begin
            out_d = mk_out(STAT_NOTFOUND, '0, '0, 1'b1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      needs_sort_q <= 1'b0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      mode_q       <= MODE_BINARY;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      needs_sort_q <= needs_sort_d;
      pend_v_q     <= pend_v_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    top_q      <= top_d;
    mid_q      <= mid_d;
    pend_pos_q <= pend_pos_d;
    hold_q     <= hold_d;
    pend_q     <= pend_d;
    key_q      <= key_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SRTS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH))
  `SRTS_ASSERT_NEXT(a_load_result, in_fire && (in_data_i.operation == OP_LOAD),
                    out_valid_o && out_data_o.last)
  `SRTS_ASSERT_NEXT(a_search_busy, in_fire && (in_data_i.operation == OP_SEARCH),
                    state_q != S_IDLE)

endmodule

// File: tb/sorted_record_table_search_tb.sv
// Testbench for the sorted record table search block: loads, sorts and searches.
`timescale 1ns / 100ps

module sorted_record_table_search_tb;
  import srts_pkg::*;

  localparam int unsigned DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  // Predictor copy of the table and the mode register.
  logic signed [KEY_W-1:0] tbl_key [DEPTH];
  logic [PAY_W-1:0] tbl_pay [DEPTH];
  int unsigned tbl_count;
  bit tbl_dirty;
  logic mode_q;

  out_t expected_results[$];
  int unsigned fail_count;
  bit hold_off;
  // Pool of keys already loaded, so that searches hit often.
  logic signed [KEY_W-1:0] key_pool[$];

  sorted_record_table_search #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic out_t make_result(logic [1:0] st, logic signed [KEY_W-1:0] k,
                                       logic [PAY_W-1:0] p, int unsigned pos, logic lst);
    out_t r;
    r.status = st;
    r.found_key = k;
    r.found_payload = p;
    r.position = pos[POS_W-1:0];
    r.last = lst;
    return r;
  endfunction

  // Stable bubble sort on the signed key, payload travels with the key.
  task automatic sort_records();
    logic signed [KEY_W-1:0] tk;
    logic [PAY_W-1:0] tp;
    for (int p = 0; p + 1 < tbl_count; p++)
      for (int j = 0; j + 1 < tbl_count - p; j++)
        if (tbl_key[j+1] < tbl_key[j]) begin
          tk = tbl_key[j]; tbl_key[j] = tbl_key[j+1]; tbl_key[j+1] = tk;
          tp = tbl_pay[j]; tbl_pay[j] = tbl_pay[j+1]; tbl_pay[j+1] = tp;
        end
  endtask

  task automatic predict_item(in_t it);
    int lo, hi, mid, hits;
    bit done;
    if (it.operation == OP_LOAD) begin
      if (it.first_record) tbl_count = 0;
      if (tbl_count >= DEPTH) begin
        expected_results.push_back(make_result(STAT_DROPPED, '0, '0, 0, 1'b1));
      end else begin
        tbl_key[tbl_count] = it.key;
        tbl_pay[tbl_count] = it.payload;
        expected_results.push_back(make_result(STAT_LOADED, '0, '0, tbl_count, 1'b1));
        tbl_count++;
        tbl_dirty = 1'b1;
        key_pool.push_back(it.key);
      end
      return;
    end
    if (tbl_dirty) begin
      sort_records();
      tbl_dirty = 1'b0;
    end
    if (mode_q == MODE_BINARY) begin
      lo = 0;
      hi = int'(tbl_count) - 1;
      done = 1'b0;
      while (lo <= hi && !done) begin
        mid = (lo + hi) / 2;
        if (tbl_key[mid] == it.key) begin
          expected_results.push_back(make_result(STAT_FOUND, tbl_key[mid], tbl_pay[mid],
                                                 mid, 1'b1));
          done = 1'b1;
        end else if (it.key < tbl_key[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
      if (!done) expected_results.push_back(make_result(STAT_NOTFOUND, '0, '0, 0, 1'b1));
    end else begin
      hits = 0;
      for (int i = 0; i < tbl_count; i++)
        if (tbl_key[i] == it.key) begin
          expected_results.push_back(make_result(STAT_FOUND, tbl_key[i], tbl_pay[i],
                                                 i, 1'b0));
          hits++;
        end
      if (hits == 0) expected_results.push_back(make_result(STAT_NOTFOUND, '0, '0, 0, 1'b1));
      else expected_results[$].last = 1'b1;
    end
  endtask

  // Sends one item, holds it until accepted, predicts at acceptance.
  // Without keep_valid the valid drops for one cycle after the transfer.
  task automatic send_item(logic op, logic first, logic signed [KEY_W-1:0] k,
                           logic [PAY_W-1:0] p, bit keep_valid);
    in_t it;
    it.operation = op;
    it.first_record = first;
    it.key = k;
    it.payload = p;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
    if (!keep_valid) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic load_rec(logic first, logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    send_item(OP_LOAD, first, k, p, 1'b0);
  endtask

  task automatic search_key(logic signed [KEY_W-1:0] k);
    send_item(OP_SEARCH, 1'b0, k, $urandom, 1'b0);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_mode(logic m);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 7)) - 32'd4);
      default: return $urandom;
    endcase
  endfunction

  // Empty table, extreme keys, duplicates and a full table with a dropped load.
  task automatic test_directed();
    search_key(32'sd5);
    load_rec(1'b1, 32'sh7fff_ffff, 32'hffff_ffff);
    load_rec(1'b0, 32'sh8000_0000, 32'h0000_0000);
    load_rec(1'b0, 32'sd0, 32'h5555_aaaa);
    load_rec(1'b0, 32'sd0, 32'haaaa_5555);
    load_rec(1'b0, -32'sd1, 32'h1234_5678);
    search_key(32'sh7fff_ffff);
    search_key(32'sh8000_0000);
    search_key(32'sd0);
    search_key(32'sd7);
    set_mode(MODE_SEQ);
    search_key(32'sd0);
    search_key(-32'sd1);
    search_key(32'sd9);
    load_rec(1'b1, 32'sd3, 32'h0);
    for (int i = 1; i < DEPTH; i++) load_rec(1'b0, $signed(32'(i % 4)), $urandom);
    load_rec(1'b0, 32'sd1, 32'hdead_beef);
    search_key(32'sd3);
    set_mode(MODE_BINARY);
    search_key(32'sd2);
  endtask

  // Random mix of loads and searches in bursts, with gaps between some bursts.
  task automatic test_random(int unsigned n_items);
    int unsigned sent = 0;
    int unsigned burst;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        if ($urandom_range(0, 2) == 0 || tbl_count == 0)
          send_item(OP_LOAD, ($urandom_range(0, 15) == 0), pick_key(), $urandom,
                    (b + 1 < burst) && (sent + 1 < n_items));
        else
          send_item(OP_SEARCH, $urandom_range(0, 1), pick_key(), $urandom,
                    (b + 1 < burst) && (sent + 1 < n_items));
        sent++;
      end
      if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 8)) @(posedge clk_i);
      if ($urandom_range(0, 9) == 0 && key_pool.size() > 40) key_pool.delete();
    end
  endtask

  // Receiver holds off while loads keep coming, then searches follow and the sender waits for drain.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) load_rec(i == 0, $signed(32'($urandom_range(0, 5))), $urandom);
    hold_off = 1'b0;
    for (int i = 0; i < 10; i++) search_key($signed(32'($urandom_range(0, 6))));
    wait_drained();
  endtask

  // Receiver stall pattern; a long hold-off is counted in cycles here.
  initial begin
    int unsigned hold_cnt;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < 200) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        out_stall_i <= 1'b0;
        wait (!hold_off);
      end else if ($urandom_range(0, 99) < 50) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_data_o.status);
          fail_count++;
        end
        if (out_data_o.found_key !== exp_r.found_key) begin
          $display("%0t: key expected %0d actual %0d", $time, exp_r.found_key,
                   out_data_o.found_key);
          fail_count++;
        end
        if (out_data_o.found_payload !== exp_r.found_payload) begin
          $display("%0t: payload expected %h actual %h", $time, exp_r.found_payload,
                   out_data_o.found_payload);
          fail_count++;
        end
        if (out_data_o.position !== exp_r.position) begin
          $display("%0t: position expected %0d actual %0d", $time, exp_r.position,
                   out_data_o.position);
          fail_count++;
        end
        if (out_data_o.last !== exp_r.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_r.last, out_data_o.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned guard;
    tbl_count = 0;
    tbl_dirty = 1'b0;
    mode_q = MODE_BINARY;
    fail_count = 0;
    hold_off = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_mode(MODE_SEQ);
    test_backpressure();
    test_random(110);
    set_mode(MODE_BINARY);
    test_random(110);
    set_mode(MODE_SEQ);
    test_random(20);
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
